FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Transfer payloads, operation and attribute codes, register indexes,
// control character codes and the sequencer state type.
// ----------------------------------------------------------------------------
package tcw_pkg;

	typedef enum logic [1:0] {
		OP_PRINT  = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_SETCUR = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	localparam logic [1:0] ATTR_NORMAL   = 2'd0;
	localparam logic [1:0] ATTR_KERNEL   = 2'd1;
	localparam logic [1:0] ATTR_USER     = 2'd2;
	// Unassigned attribute code; it selects the normal color.
	localparam logic [1:0] ATTR_RESERVED = 2'd3;

	localparam logic [1:0] REG_NORMAL_COLOR  = 2'd0;
	localparam logic [1:0] REG_KERNEL_COLOR  = 2'd1;
	localparam logic [1:0] REG_PROGRAM_COLOR = 2'd2;

	localparam logic [7:0] NORMAL_COLOR_RST  = 8'd7;
	localparam logic [7:0] KERNEL_COLOR_RST  = 8'd4;
	localparam logic [7:0] PROGRAM_COLOR_RST = 8'd2;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int TAB_STEP = 8;

	typedef struct packed {
		logic [7:0] color;
		logic [7:0] chr;
	} cell_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] char_code;
		logic [1:0] attribute;
		logic [6:0] column;
		logic [4:0] row;
	} cmd_t;

	typedef struct packed {
		logic [6:0]  out_column;
		logic [4:0]  out_row;
		logic [10:0] cursor_offset;
		logic [7:0]  cell_char;
		logic [7:0]  cell_color;
	} rsp_t;

	typedef struct packed {
		logic [1:0] index;
		logic [7:0] data;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_FILL,
		ST_READ,
		ST_RESULT
	} state_t;

endpackage

FILE: rtl/tcw_chan_if.sv
// ----------------------------------------------------------------------------
// tcw_chan_if: valid/ready channel
// One transfer happens at a rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface tcw_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit: text-mode console engine
// Screen store of character/color cells with a cursor; prints, clears,
// positions the cursor and reads cells, one command at a time.
// ----------------------------------------------------------------------------
// A command is taken when cmd.ready is high and gives one response. Printing
// a character or setting the cursor goes through ST_EXEC to ST_RESULT,
// reading a cell also through ST_READ. Clearing the screen runs ST_FILL over
// every cell and a print that scrolls runs ST_COPY and then ST_FILL, since
// every cell goes through the single write port of the screen memory once.
// After reset a clearing pass over every cell fills the memory before the
// first command is taken; register writes are taken at all times. A new
// command is taken while the previous response still waits.
module text_console_writer_unit
	import tcw_pkg::*;
#(
	parameter int COLUMNS        = 80,
	parameter int ROWS_ON_SCREEN = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	tcw_chan_if.sink    cmd,
	tcw_chan_if.source  rsp,
	tcw_chan_if.sink    cfg
);

	localparam int CELL_COUNT = COLUMNS * ROWS_ON_SCREEN;
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS_ON_SCREEN);
	localparam int ADDR_W     = $clog2(CELL_COUNT);

	localparam logic [ADDR_W-1:0] FILL_LAST = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELL_COUNT - COLUMNS - 1);
	localparam logic [ADDR_W-1:0] ROW_BASE  = ADDR_W'(CELL_COUNT - COLUMNS);
	localparam logic [ADDR_W-1:0] SRC_FIRST = ADDR_W'(COLUMNS);
	localparam logic [ADDR_W-1:0] SRC_STEP  = ADDR_W'(COLUMNS + 1);
	localparam logic [COL_W:0]    TAB_MASK  = (COL_W + 1)'(TAB_STEP - 1);
	localparam logic [COL_W:0]    COL_LIMIT = (COL_W + 1)'(COLUMNS);

	state_t state_q, state_d;

	logic [7:0] normal_color_q, kernel_color_q, program_color_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic [ADDR_W-1:0] ptr_q;
	cell_t             fill_q;
	logic              out_valid_q;

	op_t              op_q;
	logic [7:0]       ch_q;
	logic [7:0]       colour_q;
	logic [COL_W-1:0] col_in_q;
	logic [ROW_W-1:0] row_in_q;
	cell_t            cell_q;
	rsp_t             rsp_q;

	cell_t             screen_mem [CELL_COUNT];
	cell_t             rdata_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	cell_t             mem_wdata;

	// Shared cell index unit: row * COLUMNS + column.
	logic [ROW_W-1:0]  idx_row;
	logic [COL_W-1:0]  idx_col;
	logic [ADDR_W-1:0] idx_sum;

	assign idx_sum = ADDR_W'(idx_row * COLUMNS) + ADDR_W'(idx_col);

	logic cmd_ready;
	logic slot_free;
	logic cmd_xfer;
	logic cfg_xfer;

	assign cmd.ready = cmd_ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.payload = rsp_q;
	assign slot_free = !out_valid_q || rsp.ready;
	assign cmd_xfer = cmd.valid && cmd_ready;
	assign cfg_xfer = cfg.valid && 1'b1;

	// Saturation of the requested coordinates.
	logic [COL_W+6:0] col_ext;
	logic [ROW_W+4:0] row_ext;
	logic [COL_W-1:0] col_sat;
	logic [ROW_W-1:0] row_sat;

	always_comb begin
		col_ext = {COL_W'(0), cmd.payload.column};
		row_ext = {ROW_W'(0), cmd.payload.row};
		if (col_ext > (COL_W + 7)'(COLUMNS - 1)) begin
			col_sat = COL_W'(COLUMNS - 1);
		end else begin
			col_sat = col_ext[COL_W-1:0];
		end
		if (row_ext > (ROW_W + 5)'(ROWS_ON_SCREEN - 1)) begin
			row_sat = ROW_W'(ROWS_ON_SCREEN - 1);
		end else begin
			row_sat = row_ext[ROW_W-1:0];
		end
	end

	logic [7:0] attr_colour;

	always_comb begin
		case (cmd.payload.attribute)
			ATTR_KERNEL: attr_colour = kernel_color_q;
			ATTR_USER:   attr_colour = program_color_q;
			default:     attr_colour = normal_color_q;
		endcase
	end

	// Print decode against the current cursor.
	logic [COL_W:0]   cur_col_ext;
	logic [COL_W:0]   nxt_col;
	logic [COL_W-1:0] wr_col;
	logic [7:0]       wr_char;
	logic             print_wr;
	logic             line_feed;
	logic             new_line;
	logic             scroll;
	logic             is_print;

	always_comb begin
		cur_col_ext = {1'b0, cur_col_q};
		nxt_col     = cur_col_ext;
		wr_col      = cur_col_q;
		wr_char     = ch_q;
		print_wr    = 1'b0;
		line_feed   = 1'b0;
		case (ch_q)
			CH_TAB: nxt_col = (cur_col_ext | TAB_MASK) + (COL_W + 1)'(1);
			CH_CR:  nxt_col = '0;
			CH_LF:  line_feed = 1'b1;
			CH_BS: begin
				if (cur_col_q != '0) begin
					nxt_col  = cur_col_ext - (COL_W + 1)'(1);
					wr_col   = cur_col_q - COL_W'(1);
					wr_char  = CH_SPACE;
					print_wr = 1'b1;
				end
			end
			default: begin
				nxt_col  = cur_col_ext + (COL_W + 1)'(1);
				print_wr = 1'b1;
			end
		endcase
		is_print = (op_q == OP_PRINT) && (ch_q != CH_NUL);
		new_line = line_feed || (nxt_col >= COL_LIMIT);
		scroll   = new_line && (cur_row_q == ROW_W'(ROWS_ON_SCREEN - 1));
	end

	logic copy_last;
	assign copy_last = (ptr_q == COPY_LAST);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (ptr_q == FILL_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (op_q)
					OP_CLEAR:  state_d = ST_FILL;
					OP_READ:   state_d = ST_READ;
					OP_PRINT:  state_d = (is_print && scroll) ? ST_COPY : ST_RESULT;
					default:   state_d = ST_RESULT;
				endcase
			end
			ST_COPY: begin
				if (copy_last) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (ptr_q == FILL_LAST) begin
					state_d = ST_RESULT;
				end
			end
			ST_READ: state_d = ST_RESULT;
			ST_RESULT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	// Memory and handshake controls.
	always_comb begin
		cmd_ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = fill_q;
		mem_raddr = '0;
		idx_row   = cur_row_q;
		idx_col   = cur_col_q;
		case (state_q)
			ST_INIT, ST_FILL: mem_we = 1'b1;
			ST_IDLE: cmd_ready = 1'b1;
			ST_EXEC: begin
				if (op_q == OP_READ) begin
					idx_row   = row_in_q;
					idx_col   = col_in_q;
					mem_raddr = idx_sum;
				end else if (is_print) begin
					idx_col   = wr_col;
					mem_we    = print_wr;
					mem_waddr = idx_sum;
					mem_wdata = '{color: colour_q, chr: wr_char};
					if (scroll) begin
						mem_raddr = SRC_FIRST;
					end
				end
			end
			ST_COPY: begin
				// Row r+1 moves to row r; the read runs one cell ahead of the write.
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = rdata_q;
				mem_raddr = copy_last ? '0 : ptr_q + SRC_STEP;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= screen_mem[mem_raddr];
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_INIT;
			ptr_q           <= '0;
			fill_q          <= '{color: PROGRAM_COLOR_RST, chr: CH_NUL};
			out_valid_q     <= 1'b0;
			cur_col_q       <= '0;
			cur_row_q       <= '0;
			normal_color_q  <= NORMAL_COLOR_RST;
			kernel_color_q  <= KERNEL_COLOR_RST;
			program_color_q <= PROGRAM_COLOR_RST;
		end else begin
			state_q <= state_d;

			if (cfg_xfer) begin
				case (cfg.payload.index)
					REG_NORMAL_COLOR:  normal_color_q  <= cfg.payload.data;
					REG_KERNEL_COLOR:  kernel_color_q  <= cfg.payload.data;
					REG_PROGRAM_COLOR: program_color_q <= cfg.payload.data;
					default: ;
				endcase
			end

			if (state_q == ST_RESULT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_INIT, ST_FILL: ptr_q <= ptr_q + ADDR_W'(1);
				ST_EXEC: begin
					case (op_q)
						OP_CLEAR: begin
							ptr_q     <= '0;
							fill_q    <= '{color: program_color_q, chr: CH_NUL};
							cur_col_q <= '0;
							cur_row_q <= '0;
						end
						OP_SETCUR: begin
							cur_col_q <= col_in_q;
							cur_row_q <= row_in_q;
						end
						OP_PRINT: begin
							if (is_print) begin
								ptr_q <= '0;
								if (new_line) begin
									cur_col_q <= '0;
									if (!scroll) begin
										cur_row_q <= cur_row_q + ROW_W'(1);
									end
								end else begin
									cur_col_q <= nxt_col[COL_W-1:0];
								end
							end
						end
						default: ;
					endcase
				end
				ST_COPY: begin
					if (copy_last) begin
						ptr_q  <= ROW_BASE;
						fill_q <= '{color: colour_q, chr: CH_SPACE};
					end else begin
						ptr_q <= ptr_q + ADDR_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	logic [ADDR_W+10:0] ofs_wide;
	logic [COL_W+6:0]   out_col_wide;
	logic [ROW_W+4:0]   out_row_wide;

	assign ofs_wide     = {11'b0, idx_sum};
	assign out_col_wide = {7'b0, cur_col_q};
	assign out_row_wide = {5'b0, cur_row_q};

	// Command and response payload.
	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			op_q     <= op_t'(cmd.payload.operation);
			ch_q     <= cmd.payload.char_code;
			colour_q <= attr_colour;
			col_in_q <= col_sat;
			row_in_q <= row_sat;
			cell_q   <= '0;
		end
		if (state_q == ST_READ) begin
			cell_q <= rdata_q;
		end
		if (state_q == ST_RESULT && slot_free) begin
			rsp_q.out_column    <= out_col_wide[6:0];
			rsp_q.out_row       <= out_row_wide[4:0];
			rsp_q.cursor_offset <= ofs_wide[10:0];
			rsp_q.cell_char     <= cell_q.chr;
			rsp_q.cell_color    <= cell_q.color;
		end
	end

`ifndef ASSERT_OFF
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer |=> !cmd.ready)
		else $error("command taken while the previous one is still in work");

	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_RESULT) |-> !mem_we)
		else $error("screen memory written outside a command");

	a_cursor_in_screen: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.payload.out_column < COLUMNS &&
			rsp.payload.out_row < ROWS_ON_SCREEN))
		else $error("reported cursor lies outside the screen");

	a_copy_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COPY) |-> (ptr_q <= COPY_LAST && cur_col_q == '0))
		else $error("scroll copy out of range or cursor not at column zero");
`endif

endmodule
